/* src/prtd_pkg.sv */
// shared types, constants and the microcode table of the prime range tester
`timescale 1ns / 1ps
package prtd_pkg;

    // default internal value width and widest range accepted
    localparam int VALUE_WIDTH_DEF = 16;
    localparam int MAX_SPAN        = 64;
    localparam int PC_W            = 4;

    // status codes of a result
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_WIDE  = 2'd2;

    // command transaction
    typedef struct packed {
        logic [15:0] range_low;
        logic [15:0] range_high;
    } t_cmd;

    // result transaction
    typedef struct packed {
        logic [15:0] number;
        logic        is_prime;
        logic        last;
        logic [1:0]  status;
    } t_result;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_INIT_NUM,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_NEXT_DIV,
        OP_EMIT_OK,
        OP_INC_NUM,
        OP_EMIT_EMPTY,
        OP_EMIT_WIDE
    } t_op;

    // jump conditions
    typedef enum logic [2:0] {
        CD_NEVER,
        CD_ALWAYS,
        CD_NO_START,
        CD_EMPTY,
        CD_WIDE,
        CD_TEST_DONE,
        CD_DIV_MORE,
        CD_LAST
    } t_cond;

    // one control word
    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_ctrl;

    // program step addresses
    localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
    localparam logic [PC_W-1:0] PC_CHK_EMPT = 4'd1;
    localparam logic [PC_W-1:0] PC_CHK_WIDE = 4'd2;
    localparam logic [PC_W-1:0] PC_NUM      = 4'd3;
    localparam logic [PC_W-1:0] PC_TEST     = 4'd4;
    localparam logic [PC_W-1:0] PC_DIV_ST   = 4'd5;
    localparam logic [PC_W-1:0] PC_DIV_STEP = 4'd6;
    localparam logic [PC_W-1:0] PC_NEXT_DIV = 4'd7;
    localparam logic [PC_W-1:0] PC_EMIT     = 4'd8;
    localparam logic [PC_W-1:0] PC_INC      = 4'd9;
    localparam logic [PC_W-1:0] PC_EMPTY    = 4'd10;
    localparam logic [PC_W-1:0] PC_WIDE     = 4'd11;

    // microcode rom: jump to target when the condition holds, else step on
    function automatic t_ctrl f_ucode(input logic [PC_W-1:0] pc);
        t_ctrl w;
        w = '{op: OP_NOP, cond: CD_ALWAYS, target: PC_IDLE};
        case (pc)
            PC_IDLE:     w = '{op: OP_LOAD,       cond: CD_NO_START,  target: PC_IDLE};
            PC_CHK_EMPT: w = '{op: OP_NOP,        cond: CD_EMPTY,     target: PC_EMPTY};
            PC_CHK_WIDE: w = '{op: OP_NOP,        cond: CD_WIDE,      target: PC_WIDE};
            PC_NUM:      w = '{op: OP_INIT_NUM,   cond: CD_NEVER,     target: PC_IDLE};
            PC_TEST:     w = '{op: OP_NOP,        cond: CD_TEST_DONE, target: PC_EMIT};
            PC_DIV_ST:   w = '{op: OP_DIV_START,  cond: CD_NEVER,     target: PC_IDLE};
            PC_DIV_STEP: w = '{op: OP_DIV_STEP,   cond: CD_DIV_MORE,  target: PC_DIV_STEP};
            PC_NEXT_DIV: w = '{op: OP_NEXT_DIV,   cond: CD_ALWAYS,    target: PC_TEST};
            PC_EMIT:     w = '{op: OP_EMIT_OK,    cond: CD_LAST,      target: PC_IDLE};
            PC_INC:      w = '{op: OP_INC_NUM,    cond: CD_ALWAYS,    target: PC_NUM};
            PC_EMPTY:    w = '{op: OP_EMIT_EMPTY, cond: CD_ALWAYS,    target: PC_IDLE};
            PC_WIDE:     w = '{op: OP_EMIT_WIDE,  cond: CD_ALWAYS,    target: PC_IDLE};
            default:     w = '{op: OP_NOP,        cond: CD_ALWAYS,    target: PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

/* src/prime_range_trial_division.sv */
// Prime range tester: one command gives a range, one result per number of it.
// A command is taken at a clock edge where start is high and busy is low. An
// empty range or one of more than MAX_SPAN numbers gives a single result with
// status set and last high; else each number of the range, in ascending order,
// gives one result with its prime flag, the final one marked by last. Each
// result shows on o_result for one cycle under o_strobe and cannot be held off,
// so the receiver must take it then. Each number n is tested against k trial
// divisors (up to floor(sqrt(n))-1, fewer once a factor shows up), each through
// the bit-serial remainder unit, one quotient bit a cycle. The range checks run
// once per command, ahead of the first number.
`timescale 1ns / 1ps
module prime_range_trial_division #(
    parameter int VALUE_WIDTH = prtd_pkg::VALUE_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  prtd_pkg::t_cmd   i_cmd,
    output logic             busy,
    output logic             o_strobe,
    output prtd_pkg::t_result o_result
);
    import prtd_pkg::*;

    localparam int SQ_W  = VALUE_WIDTH + 2;
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    // sequencer and datapath registers
    logic [PC_W-1:0]        r_pc, n_pc;
    logic [VALUE_WIDTH-1:0] r_num, n_num;
    logic [VALUE_WIDTH-1:0] r_hi, n_hi;
    logic [VALUE_WIDTH-1:0] r_d, n_d;
    logic [SQ_W-1:0]        r_sq, n_sq;
    logic [VALUE_WIDTH-1:0] r_rem, n_rem;
    logic [VALUE_WIDTH-1:0] r_quo, n_quo;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_prime, n_prime;
    logic                   r_strobe, n_strobe;
    t_result                r_res, n_res;

    t_ctrl                  w_ctrl;
    logic                   w_take;
    logic                   w_empty;
    logic                   w_wide;
    logic                   w_last;
    logic [VALUE_WIDTH:0]   w_trial;
    logic [VALUE_WIDTH:0]   w_diff;

    assign busy     = (r_pc != PC_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

    // range checks and one restoring division step
    assign w_ctrl  = f_ucode(r_pc);
    assign w_empty = (r_num > r_hi);
    assign w_wide  = (32'(r_hi - r_num) >= 32'(MAX_SPAN));
    assign w_last  = (r_num == r_hi);
    assign w_trial = {r_rem, r_quo[VALUE_WIDTH-1]};
    assign w_diff  = w_trial - {1'b0, r_d};

    // jump condition and next step
    always_comb begin
        case (w_ctrl.cond)
            CD_NEVER:     w_take = 1'b0;
            CD_ALWAYS:    w_take = 1'b1;
            CD_NO_START:  w_take = !start;
            CD_EMPTY:     w_take = w_empty;
            CD_WIDE:      w_take = w_wide;
            CD_TEST_DONE: w_take = !r_prime || (r_sq > SQ_W'(r_num));
            CD_DIV_MORE:  w_take = (r_cnt != CNT_W'(1));
            CD_LAST:      w_take = w_last;
            default:      w_take = 1'b1;
        endcase
        n_pc = w_take ? w_ctrl.target : r_pc + PC_W'(1);
    end

    // datapath driven by the control word
    always_comb begin
        n_num    = r_num;
        n_hi     = r_hi;
        n_d      = r_d;
        n_sq     = r_sq;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_cnt    = r_cnt;
        n_prime  = r_prime;
        n_strobe = 1'b0;
        n_res    = r_res;
        case (w_ctrl.op)
            OP_NOP: begin
            end
            OP_LOAD: begin
                n_num = VALUE_WIDTH'(i_cmd.range_low);
                n_hi  = VALUE_WIDTH'(i_cmd.range_high);
            end
            OP_INIT_NUM: begin
                n_prime = (r_num >= VALUE_WIDTH'(2));
                n_d     = VALUE_WIDTH'(2);
                n_sq    = SQ_W'(4);
            end
            OP_DIV_START: begin
                n_rem = '0;
                n_quo = r_num;
                n_cnt = CNT_W'(VALUE_WIDTH);
            end
            OP_DIV_STEP: begin
                n_rem = w_diff[VALUE_WIDTH] ? w_trial[VALUE_WIDTH-1:0]
                                            : w_diff[VALUE_WIDTH-1:0];
                n_quo = {r_quo[VALUE_WIDTH-2:0], 1'b0};
                n_cnt = r_cnt - CNT_W'(1);
            end
            OP_NEXT_DIV: begin
                if (r_rem == '0) begin
                    n_prime = 1'b0;
                end
                n_d  = r_d + VALUE_WIDTH'(1);
                n_sq = r_sq + SQ_W'({r_d, 1'b1});
            end
            OP_EMIT_OK: begin
                n_strobe = 1'b1;
                n_res    = '{number: 16'(r_num), is_prime: r_prime, last: w_last,
                             status: STATUS_OK};
            end
            OP_INC_NUM: begin
                n_num = r_num + VALUE_WIDTH'(1);
            end
            OP_EMIT_EMPTY: begin
                n_strobe = 1'b1;
                n_res    = '{number: '0, is_prime: 1'b0, last: 1'b1,
                             status: STATUS_EMPTY};
            end
            OP_EMIT_WIDE: begin
                n_strobe = 1'b1;
                n_res    = '{number: '0, is_prime: 1'b0, last: 1'b1,
                             status: STATUS_WIDE};
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= PC_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_pc     <= n_pc;
            r_strobe <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_num   <= n_num;
        r_hi    <= n_hi;
        r_d     <= n_d;
        r_sq    <= n_sq;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_cnt   <= n_cnt;
        r_prime <= n_prime;
        r_res   <= n_res;
    end

endmodule

/* src/prtd_chk.sv */
// port-level checks of the prime range tester and their binding
`timescale 1ns / 1ps
module prtd_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_strobe,
    input prtd_pkg::t_result o_result
);
    import prtd_pkg::*;

    // an accepted command keeps the block busy and brings no result at once
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_strobe))
        else $error("accepted command did not start work");

    // more results still to come means the block stays busy
    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |-> busy)
        else $error("non-final result while idle");

    // flagged ranges give one final result with a zero number
    a_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.status != STATUS_OK)) |->
        (o_result.last && !o_result.is_prime && (o_result.number == '0)))
        else $error("flagged result malformed");

    // zero and one are never reported prime
    a_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.is_prime) |-> (o_result.number >= 16'd2))
        else $error("number below two reported prime");

endmodule

bind prime_range_trial_division prtd_chk u_prtd_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

/* tb/tb_top.sv */
// self-checking testbench of the prime range tester: directed table, then random ranges
`timescale 1ns / 1ps
module tb_top;
    import prtd_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 6;
    localparam int LIMIT_CYCLES    = 200_000_000;
    localparam int DRAIN_CYCLES    = 200;
    localparam int ITEMS_PER_PHASE = 28;
    localparam int NUM_DIRECTED    = 18;
    localparam int TOP_VALUE       = 65535;

    // one row of the directed table, with an optional hand-written verdict
    typedef struct {
        t_cmd    cmd;
        bit      typed;
        t_result res;
    } t_range_row;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_cmd    i_cmd   = '0;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    t_result     verdicts_q[$];
    t_result     head_verdict;
    int unsigned n_bad   = 0;
    int unsigned gap_pct = 0;
    t_range_row  range_rows [NUM_DIRECTED];

    prime_range_trial_division dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // clock
    always #CLK_HALF i_clk = ~i_clk;

    // primality by trial division up to the square root
    function automatic logic is_prime_num(input int unsigned n);
        int unsigned d;
        if (n < 2) return 1'b0;
        for (d = 2; d * d <= n; d++) begin
            if (n % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    // queue the verdicts one range command should produce
    function automatic void forecast_verdicts(input t_cmd c);
        t_result     r;
        int unsigned lo;
        int unsigned hi;
        int unsigned n;
        lo = c.range_low;
        hi = c.range_high;
        if (lo > hi) begin
            r = '{number: '0, is_prime: 1'b0, last: 1'b1, status: STATUS_EMPTY};
            verdicts_q.push_back(r);
        end else if (hi - lo + 1 > MAX_SPAN) begin
            r = '{number: '0, is_prime: 1'b0, last: 1'b1, status: STATUS_WIDE};
            verdicts_q.push_back(r);
        end else begin
            for (n = lo; n <= hi; n++) begin
                r.number   = n[15:0];
                r.is_prime = is_prime_num(n);
                r.last     = (n == hi);
                r.status   = STATUS_OK;
                verdicts_q.push_back(r);
            end
        end
    endfunction

    function automatic t_range_row mk_row(input logic [15:0] lo, input logic [15:0] hi,
                                          input bit typed, input logic [15:0] num,
                                          input logic prime, input logic [1:0] st);
        t_range_row row;
        row.cmd   = '{range_low: lo, range_high: hi};
        row.typed = typed;
        row.res   = '{number: num, is_prime: prime, last: 1'b1, status: st};
        return row;
    endfunction

    // random range: mostly small values, a share anywhere, some empty and wide
    function automatic t_cmd random_range();
        t_cmd        c;
        int unsigned pick;
        int unsigned lo;
        int unsigned hi;
        int unsigned span;
        pick = $urandom_range(99);
        if (pick < 10) begin
            lo = $urandom_range(TOP_VALUE, 1);
            hi = $urandom_range(lo - 1, 0);
        end else if (pick < 18) begin
            lo = $urandom_range(TOP_VALUE - MAX_SPAN, 0);
            hi = $urandom_range(TOP_VALUE, lo + MAX_SPAN);
        end else if (pick < 40) begin
            lo   = $urandom_range(TOP_VALUE, 0);
            span = $urandom_range(3, 1);
            hi   = lo + span - 1;
            if (hi > TOP_VALUE) hi = TOP_VALUE;
        end else begin
            lo   = $urandom_range(2047, 0);
            span = ($urandom_range(19) == 0) ? MAX_SPAN : $urandom_range(8, 1);
            hi   = lo + span - 1;
        end
        c.range_low  = lo[15:0];
        c.range_high = hi[15:0];
        return c;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch on %s: got %0d, want %0d at %0t", what, got, want, $time);
        n_bad++;
    endtask

    // issue one range transaction, with random idle cycles ahead of it
    task automatic send_range(input t_cmd c, input bit typed, input t_result typed_res);
        while ($urandom_range(99) < gap_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        if (typed) verdicts_q.push_back(typed_res);
        else forecast_verdicts(c);
        start = 1'b1;
        i_cmd = c;
        do @(posedge i_clk); while (busy !== 1'b0);
        @(negedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) begin
            if (verdicts_q.size() == 0) begin
                report_mismatch("unexpected result, number", o_result.number, '0);
            end else begin
                head_verdict = verdicts_q.pop_front();
                if (o_result.number !== head_verdict.number)
                    report_mismatch("number", o_result.number, head_verdict.number);
                if (o_result.is_prime !== head_verdict.is_prime)
                    report_mismatch("is_prime", 16'(o_result.is_prime),
                                    16'(head_verdict.is_prime));
                if (o_result.last !== head_verdict.last)
                    report_mismatch("last", 16'(o_result.last), 16'(head_verdict.last));
                if (o_result.status !== head_verdict.status)
                    report_mismatch("status", 16'(o_result.status),
                                    16'(head_verdict.status));
            end
        end
    end

    // stimulus
    initial begin
        int k;
        int phase;
        // extremes, empty and wide ranges with verdicts written out
        range_rows[0]  = mk_row(16'd0, 16'd0, 1'b1, 16'd0, 1'b0, STATUS_OK);
        range_rows[1]  = mk_row(16'd1, 16'd1, 1'b1, 16'd1, 1'b0, STATUS_OK);
        range_rows[2]  = mk_row(16'd2, 16'd2, 1'b1, 16'd2, 1'b1, STATUS_OK);
        range_rows[3]  = mk_row(16'd65535, 16'd65535, 1'b1, 16'd65535, 1'b0, STATUS_OK);
        range_rows[4]  = mk_row(16'd5, 16'd4, 1'b1, 16'd0, 1'b0, STATUS_EMPTY);
        range_rows[5]  = mk_row(16'd65535, 16'd0, 1'b1, 16'd0, 1'b0, STATUS_EMPTY);
        range_rows[6]  = mk_row(16'd1, 16'd0, 1'b1, 16'd0, 1'b0, STATUS_EMPTY);
        range_rows[7]  = mk_row(16'd0, 16'd64, 1'b1, 16'd0, 1'b0, STATUS_WIDE);
        range_rows[8]  = mk_row(16'd0, 16'd65535, 1'b1, 16'd0, 1'b0, STATUS_WIDE);
        range_rows[9]  = mk_row(16'd65471, 16'd65535, 1'b1, 16'd0, 1'b0, STATUS_WIDE);
        // widest accepted spans at both ends, largest prime, bit patterns
        range_rows[10] = mk_row(16'd0, 16'd63, 1'b0, '0, 1'b0, STATUS_OK);
        range_rows[11] = mk_row(16'd65472, 16'd65535, 1'b0, '0, 1'b0, STATUS_OK);
        range_rows[12] = mk_row(16'd65521, 16'd65521, 1'b0, '0, 1'b0, STATUS_OK);
        range_rows[13] = mk_row(16'd32749, 16'd32771, 1'b0, '0, 1'b0, STATUS_OK);
        range_rows[14] = mk_row(16'd0, 16'd1, 1'b0, '0, 1'b0, STATUS_OK);
        range_rows[15] = mk_row(16'd97, 16'd99, 1'b0, '0, 1'b0, STATUS_OK);
        range_rows[16] = mk_row(16'd21845, 16'd21850, 1'b0, '0, 1'b0, STATUS_OK);
        range_rows[17] = mk_row(16'd43690, 16'd43700, 1'b0, '0, 1'b0, STATUS_OK);

        // reset
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        gap_pct = 38;
        for (k = 0; k < NUM_DIRECTED; k++)
            send_range(range_rows[k].cmd, range_rows[k].typed, range_rows[k].res);

        // random phases: sender idling often, very often, then never
        for (phase = 0; phase < 3; phase++) begin
            gap_pct = (phase == 0) ? 38 : (phase == 1) ? 85 : 0;
            for (k = 0; k < ITEMS_PER_PHASE; k++)
                send_range(random_range(), 1'b0, '0);
        end
        start = 1'b0;

        // drain
        while (verdicts_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_bad == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    // watchdog
    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
